// ===== hw/rtl/jsp_pkg.sv =====
// Shared types and codes for the joint slot pool.
package jsp_pkg;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_DROP   = 3'd3,
    ACT_READ   = 3'd4
  } jsp_action_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_IGNORED = 2'd2
  } jsp_status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  slot_index;
    logic [9:0]  first_object;
    logic [9:0]  second_object;
    logic [31:0] anchor_x;
    logic [31:0] anchor_y;
    logic [31:0] anchor_z;
    logic [9:0]  drop_object;
  } jsp_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  granted_slot;
    logic [6:0]  active_count;
    logic        entry_active;
    logic [9:0]  entry_first_object;
    logic [9:0]  entry_second_object;
    logic [31:0] entry_anchor_x;
    logic [31:0] entry_anchor_y;
    logic [31:0] entry_anchor_z;
  } jsp_result_t;

endpackage

// ===== hw/rtl/joint_slot_pool.sv =====
// Joint slot pool: lowest-free allocation over a slot memory, one slot per cycle.
//
//   channel   direction  handshake            word
//   command   in         start & !busy        cmd    (jsp_cmd_t)
//   result    out        done, one cycle      result (jsp_result_t)
//
// Slots live in one memory with a registered read port; a single compare unit
// walks it one slot per cycle. Clear writes every slot; add stops at the first
// free slot; drop scans them all; remove and read visit the indexed slot; a bad
// index or unknown action is answered from idle. Reset clears every slot with
// busy high. The result is shown for one cycle and the receiver cannot stall.
module joint_slot_pool
  import jsp_pkg::*;
#(
  parameter int SLOT_COUNT        = 64,
  parameter int OBJECT_INDEX_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  jsp_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output jsp_result_t result
);

  localparam int SLOT_BITS = $clog2(SLOT_COUNT);
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int EXT_W     = (CNT_W > 7) ? CNT_W : 7;
  localparam int OBJ_EXT   = (OBJECT_INDEX_BITS > 10) ? OBJECT_INDEX_BITS : 10;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

  typedef struct packed {
    logic                         active;
    logic [OBJECT_INDEX_BITS-1:0] first_object;
    logic [OBJECT_INDEX_BITS-1:0] second_object;
    logic [31:0]                  anchor_x;
    logic [31:0]                  anchor_y;
    logic [31:0]                  anchor_z;
  } slot_t;

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_CLEAR, ST_SCAN} state_t;

  state_t                       state;
  logic [2:0]                   act;
  logic [SLOT_BITS-1:0]         ptr;
  logic [SLOT_BITS-1:0]         end_slot;
  logic [SLOT_BITS-1:0]         rd_ptr;
  logic                         issuing;
  logic                         rd_valid;
  logic [CNT_W-1:0]             count;
  slot_t                        add_entry;
  logic [OBJECT_INDEX_BITS-1:0] drop_obj;

  slot_t                        mem [SLOT_COUNT];
  slot_t                        mem_q;

  logic                         we;
  logic [SLOT_BITS-1:0]         wa;
  slot_t                        wd;
  logic [CNT_W-1:0]             count_next;
  logic                         fin;
  jsp_result_t                  res;
  logic [EXT_W-1:0]             cnt_ext;
  logic [EXT_W-1:0]             grant_ext;
  logic [EXT_W-1:0]             idx_ext;
  logic                         in_range;
  logic                         is_last;
  logic                         obj_hit;
  logic [OBJ_EXT-1:0]           in_first_ext;
  logic [OBJ_EXT-1:0]           in_second_ext;
  logic [OBJ_EXT-1:0]           in_drop_ext;
  logic [OBJ_EXT-1:0]           q_first_ext;
  logic [OBJ_EXT-1:0]           q_second_ext;

  assign busy          = (state != ST_IDLE);
  assign idx_ext       = EXT_W'(cmd.slot_index);
  assign in_range      = (idx_ext < EXT_W'(SLOT_COUNT));
  assign in_first_ext  = OBJ_EXT'(cmd.first_object);
  assign in_second_ext = OBJ_EXT'(cmd.second_object);
  assign in_drop_ext   = OBJ_EXT'(cmd.drop_object);
  assign q_first_ext   = OBJ_EXT'(mem_q.first_object);
  assign q_second_ext  = OBJ_EXT'(mem_q.second_object);
  assign grant_ext     = EXT_W'(rd_ptr);
  assign is_last       = (rd_ptr == end_slot);
  assign obj_hit       = mem_q.active &&
                         ((mem_q.first_object == drop_obj) ||
                          (mem_q.second_object == drop_obj));

  always_ff @(posedge clk) begin
    mem_q <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_comb begin
    we         = 1'b0;
    wa         = rd_ptr;
    wd         = mem_q;
    wd.active  = 1'b0;
    count_next = count;
    fin        = 1'b0;
    res        = '0;
    res.status = STAT_DONE;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        we  = 1'b1;
        wa  = ptr;
        wd  = '0;
        fin = (ptr == LAST_SLOT);
      end
      ST_IDLE: begin
        res.status = STAT_IGNORED;
      end
      ST_SCAN: begin
        if (rd_valid) begin
          unique case (act)
            ACT_ADD: begin
              if (!mem_q.active) begin
                we                = 1'b1;
                wd                = add_entry;
                count_next        = count + CNT_W'(1);
                fin               = 1'b1;
                res.granted_slot  = grant_ext[5:0];
              end else if (is_last) begin
                fin        = 1'b1;
                res.status = STAT_FULL;
              end
            end
            ACT_DROP: begin
              if (obj_hit) begin
                we         = 1'b1;
                count_next = count - CNT_W'(1);
              end
              fin = is_last;
            end
            ACT_REMOVE: begin
              fin = 1'b1;
              if (mem_q.active) begin
                we         = 1'b1;
                count_next = count - CNT_W'(1);
              end else begin
                res.status = STAT_IGNORED;
              end
            end
            default: begin
              fin = 1'b1;
              if (mem_q.active) begin
                res.entry_active        = 1'b1;
                res.entry_first_object  = q_first_ext[9:0];
                res.entry_second_object = q_second_ext[9:0];
                res.entry_anchor_x      = mem_q.anchor_x;
                res.entry_anchor_y      = mem_q.anchor_y;
                res.entry_anchor_z      = mem_q.anchor_z;
              end else begin
                res.status = STAT_IGNORED;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    cnt_ext          = EXT_W'(count_next);
    res.active_count = cnt_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      ptr      <= '0;
      count    <= '0;
      done     <= 1'b0;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done  <= 1'b0;
      count <= count_next;
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          if (fin) begin
            done   <= (state == ST_CLEAR);
            result <= res;
            state  <= ST_IDLE;
          end else begin
            ptr <= ptr + SLOT_BITS'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            act                     <= cmd.action;
            add_entry.active        <= 1'b1;
            add_entry.first_object  <= in_first_ext[OBJECT_INDEX_BITS-1:0];
            add_entry.second_object <= in_second_ext[OBJECT_INDEX_BITS-1:0];
            add_entry.anchor_x      <= cmd.anchor_x;
            add_entry.anchor_y      <= cmd.anchor_y;
            add_entry.anchor_z      <= cmd.anchor_z;
            drop_obj                <= in_drop_ext[OBJECT_INDEX_BITS-1:0];
            rd_valid                <= 1'b0;
            unique case (cmd.action)
              ACT_CLEAR: begin
                ptr   <= '0;
                count <= '0;
                state <= ST_CLEAR;
              end
              ACT_ADD, ACT_DROP: begin
                ptr      <= '0;
                end_slot <= LAST_SLOT;
                issuing  <= 1'b1;
                state    <= ST_SCAN;
              end
              ACT_REMOVE, ACT_READ: begin
                if (in_range) begin
                  ptr      <= idx_ext[SLOT_BITS-1:0];
                  end_slot <= idx_ext[SLOT_BITS-1:0];
                  issuing  <= 1'b1;
                  state    <= ST_SCAN;
                end else begin
                  done   <= 1'b1;
                  result <= res;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= res;
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_valid <= issuing;
          rd_ptr   <= ptr;
          if (issuing) begin
            if (ptr == end_slot) begin
              issuing <= 1'b0;
            end else begin
              ptr <= ptr + SLOT_BITS'(1);
            end
          end
          if (fin) begin
            done     <= 1'b1;
            result   <= res;
            issuing  <= 1'b0;
            rd_valid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/jsp_checker.sv =====
// Port-level checks for the joint slot pool, bound to joint_slot_pool.
module jsp_checker
  import jsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input jsp_result_t result
);

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither busy nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_full_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STAT_FULL)) |-> (result.granted_slot == '0))
    else $error("full pool with a granted slot");

  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.entry_active) |-> (result.status == STAT_DONE))
    else $error("entry shown with a failing status");

  a_ignored_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STAT_IGNORED)) |->
      (!result.entry_active && (result.granted_slot == '0) &&
       (result.entry_anchor_x == '0)))
    else $error("ignored word carries entry data");

endmodule

bind joint_slot_pool jsp_checker u_jsp_checker (.*);
